FILE: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: design/egc_pkg.sv
// Package: types, codes and constants of the elevator group controller.
`default_nettype none
package egc_pkg;
    localparam int DefNumCars   = 4;
    localparam int DefNumFloors = 64;
    localparam int MaxReport    = 4;

    localparam logic [1:0] REQ_FLOOR = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_EMERG = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] KIND_REQ    = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_EMERG  = 2'd2;

    localparam logic [1:0] HEAD_IDLE = 2'd0;
    localparam logic [1:0] HEAD_UP   = 2'd1;
    localparam logic [1:0] HEAD_DOWN = 2'd2;
    localparam logic [1:0] HEAD_STOP = 2'd3;

    localparam logic [0:0] REG_TOP_FLOOR = 1'd0;
    localparam logic [0:0] REG_CAR_COUNT = 1'd1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] floor;
        logic [2:0] car_choice;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       accepted;
        logic [1:0] car_index;
        logic [5:0] car_floor;
        logic [1:0] heading;
        logic       door_open;
        logic       last;
    } out_item_t;

    // Floor scan result handed from the scanner to the sequencer.
    typedef struct packed {
        logic       done;
        logic       found;
        logic [5:0] best;
        logic [1:0] head;
    } scan_res_t;
endpackage
`default_nettype wire

FILE: design/egc_scan.sv
// Nearest pending floor scanner: one floor compared per cycle.
`default_nettype none
module egc_scan
    import egc_pkg::*;
#(
    parameter int NUM_FLOORS = DefNumFloors
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [5:0]  pos,
    input  wire logic [63:0] up_set,
    input  wire logic [63:0] down_set,
    output scan_res_t        res
);
    localparam int FloorLim = (NUM_FLOORS < 64) ? NUM_FLOORS : 64;
    localparam logic [6:0] LastIdx = 7'(FloorLim - 1);

    logic       busy_reg, busy_next;
    logic       phase_reg, phase_next;   // 0 up set, 1 down set
    logic [5:0] idx_reg, idx_next;
    logic [6:0] bestd_reg, bestd_next;
    logic [5:0] best_reg, best_next;
    logic [1:0] head_reg, head_next;
    logic       found_reg, found_next;
    logic       done_reg, done_next;
    logic       hit;
    logic [6:0] d;

    always_comb
    begin
        d   = (idx_reg > pos) ? 7'(idx_reg - pos) : 7'(pos - idx_reg);
        hit = (phase_reg ? down_set[idx_reg] : up_set[idx_reg]) && (d < bestd_reg);
        busy_next  = busy_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        bestd_next = bestd_reg;
        best_next  = best_reg;
        head_next  = head_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            idx_next   = '0;
            bestd_next = 7'h7f;
            head_next  = HEAD_IDLE;
            found_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                bestd_next = d;
                best_next  = idx_reg;
                head_next  = phase_reg ? HEAD_DOWN : HEAD_UP;
                found_next = 1'b1;
            end
            if ({1'b0, idx_reg} == LastIdx)
            begin
                idx_next = '0;
                if (phase_reg)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                phase_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        idx_reg   <= idx_next;
        bestd_reg <= bestd_next;
        best_reg  <= best_next;
        head_reg  <= head_next;
        found_reg <= found_next;
    end

    assign res = '{done: done_reg, found: found_reg, best: best_reg, head: head_reg};
endmodule
`default_nettype wire

FILE: design/elevator_group_controller.sv
// Top level: elevator group controller with sequenced per-car tick processing.
//
// Channel   Direction  Handshake        Payload
// in        input      in_valid/ready   in_item_t (req_type, floor, car_choice)
// out       output     out_valid/ready  out_item_t (kind .. last)
// apb       input      psel/penable     top_floor @0x0, car_count @0x4
//
// Flow: a floor request with automatic choice walks the cars one per cycle before
// its result is stored; a chosen car goes straight to the store step; a rejection
// or an emergency item is answered from the idle state; a tick walks the cars in
// use; unless halted, a car with no target is scanned by the one-floor-per-cycle
// scanner. Each result sits in an output register; the block waits there until
// the transaction completes. Reset clears every car at once.
`default_nettype none
`include "assert_macros.svh"
module elevator_group_controller
    import egc_pkg::*;
#(
    parameter int NUM_CARS   = DefNumCars,
    parameter int NUM_FLOORS = DefNumFloors
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CarW     = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int CarLim   = (NUM_CARS < MaxReport) ? NUM_CARS : MaxReport;
    localparam int FloorLim = (NUM_FLOORS < 64) ? NUM_FLOORS : 64;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AUTO  = 3'd1;
    localparam logic [2:0] ST_CAR   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_MOVE  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] top_reg;
    logic [2:0] count_reg;
    logic       halted_reg;

    logic [5:0]  pos_reg   [NUM_CARS];
    logic [1:0]  head_reg  [NUM_CARS];
    logic [63:0] up_reg    [NUM_CARS];
    logic [63:0] down_reg  [NUM_CARS];
    logic [5:0]  tgt_reg   [NUM_CARS];
    logic        tval_reg  [NUM_CARS];

    in_item_t   item_reg;
    logic [2:0] car_reg;        // car under work (wide enough for count)
    logic [2:0] sel_reg;
    logic [6:0] bestd_reg;
    logic       tick_reg;       // tick that still has cars to walk
    out_item_t  out_reg;
    logic       ovalid_reg;

    logic [2:0]     n_cars;
    logic [CarW-1:0] ci;
    logic           scan_start;
    scan_res_t      scan;
    logic           wr;
    logic [6:0]     ad;
    logic           want_ok;
    logic [5:0]     npos;

    // Cars in use: zero acts as one, large counts clip to the car limit.
    always_comb
    begin
        n_cars = count_reg;
        if (n_cars == 3'd0)
            n_cars = 3'd1;
        if ({29'd0, n_cars} > 32'(CarLim))
            n_cars = 3'(CarLim);
    end

    assign ci = CarW'(car_reg);
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign in_ready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_item = out_reg;
    assign prdata = paddr[2] ? {29'd0, count_reg} : {26'd0, top_reg};

    always_comb
    begin
        ad = (pos_reg[ci] > item_reg.floor) ? 7'(pos_reg[ci] - item_reg.floor)
                                            : 7'(item_reg.floor - pos_reg[ci]);
        want_ok = ((up_reg[ci] == '0) && (down_reg[ci] == '0))
                  || (head_reg[ci] == ((item_reg.floor > pos_reg[ci]) ? HEAD_UP
                                                                       : HEAD_DOWN));
        npos = pos_reg[ci];
        if (pos_reg[ci] < tgt_reg[ci])
            npos = pos_reg[ci] + 6'd1;
        else if (pos_reg[ci] > tgt_reg[ci])
            npos = pos_reg[ci] - 6'd1;
    end

    egc_scan #(.NUM_FLOORS(NUM_FLOORS)) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .pos      (pos_reg[ci]),
        .up_set   (up_reg[ci]),
        .down_set (down_reg[ci]),
        .res      (scan)
    );

    assign scan_start = (state_reg == ST_CAR) && !halted_reg && !tval_reg[ci];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= 6'd63;
            count_reg <= 3'd4;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                REG_TOP_FLOOR: top_reg   <= pwdata[5:0];
                REG_CAR_COUNT: count_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Sequencer and car state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            halted_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            tick_reg   <= 1'b0;
            for (int c = 0; c < NUM_CARS; c++)
            begin
                pos_reg[c]  <= '0;
                head_reg[c] <= HEAD_IDLE;
                up_reg[c]   <= '0;
                down_reg[c] <= '0;
                tgt_reg[c]  <= '0;
                tval_reg[c] <= 1'b0;
            end
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg  <= in_item;
                        car_reg   <= '0;
                        sel_reg   <= '0;
                        bestd_reg <= 7'h7f;
                        unique case (in_item.req_type)
                            REQ_FLOOR:
                            begin
                                if ({1'b0, in_item.floor} > {1'b0, top_reg}
                                    || 32'(in_item.floor) >= 32'(FloorLim)
                                    || in_item.car_choice > n_cars)
                                begin
                                    out_reg    <= '{KIND_REQ, 1'b0, 2'd0, 6'd0,
                                                    HEAD_IDLE, 1'b0, 1'b1};
                                    ovalid_reg <= 1'b1;
                                end
                                else if (in_item.car_choice == 3'd0)
                                    state_reg <= ST_AUTO;
                                else
                                begin
                                    sel_reg   <= in_item.car_choice - 3'd1;
                                    car_reg   <= in_item.car_choice - 3'd1;
                                    state_reg <= ST_OUT;
                                end
                            end
                            REQ_TICK:
                            begin
                                tick_reg  <= 1'b1;
                                state_reg <= ST_CAR;
                            end
                            REQ_EMERG:
                            begin
                                halted_reg <= 1'b1;
                                for (int c = 0; c < NUM_CARS; c++)
                                begin
                                    tval_reg[c] <= 1'b0;
                                    head_reg[c] <= HEAD_STOP;
                                end
                                out_reg    <= '{KIND_EMERG, 1'b1, 2'd0, 6'd0,
                                                HEAD_IDLE, 1'b0, 1'b1};
                                ovalid_reg <= 1'b1;
                            end
                            REQ_CLEAR:
                            begin
                                halted_reg <= 1'b0;
                                out_reg    <= '{KIND_EMERG, 1'b1, 2'd0, 6'd0,
                                                HEAD_IDLE, 1'b0, 1'b1};
                                ovalid_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_AUTO:
                begin
                    // Walk the cars, keep the strictly nearest eligible one.
                    if (ad < bestd_reg && want_ok)
                    begin
                        bestd_reg <= ad;
                        sel_reg   <= car_reg;
                    end
                    if (car_reg + 3'd1 >= n_cars)
                    begin
                        car_reg   <= (ad < bestd_reg && want_ok) ? car_reg : sel_reg;
                        state_reg <= ST_OUT;
                    end
                    else
                        car_reg <= car_reg + 3'd1;
                end
                ST_OUT:
                begin
                    // Store the request and acknowledge it.
                    if (item_reg.floor < pos_reg[ci])
                        down_reg[ci] <= down_reg[ci] | (64'd1 << item_reg.floor);
                    else
                        up_reg[ci] <= up_reg[ci] | (64'd1 << item_reg.floor);
                    out_reg    <= '{KIND_REQ, 1'b1, 2'(car_reg), pos_reg[ci],
                                    head_reg[ci], 1'b0, 1'b1};
                    ovalid_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                ST_CAR:
                begin
                    if (!ovalid_reg)
                    begin
                        if (halted_reg)
                        begin
                            head_reg[ci] <= HEAD_STOP;
                            out_reg      <= '{KIND_STATUS, 1'b0, 2'(car_reg), pos_reg[ci],
                                              HEAD_STOP, 1'b0,
                                              car_reg + 3'd1 == n_cars};
                            ovalid_reg   <= 1'b1;
                            if (car_reg + 3'd1 == n_cars)
                            begin
                                tick_reg  <= 1'b0;
                                state_reg <= ST_IDLE;
                            end
                            else
                                car_reg <= car_reg + 3'd1;
                        end
                        else if (!tval_reg[ci])
                            state_reg <= ST_SCAN;
                        else
                            state_reg <= ST_MOVE;
                    end
                end
                ST_SCAN:
                begin
                    if (scan.done)
                    begin
                        head_reg[ci] <= scan.head;
                        if (scan.found)
                        begin
                            tgt_reg[ci]  <= scan.best;
                            tval_reg[ci] <= 1'b1;
                        end
                        state_reg <= ST_MOVE;
                    end
                end
                ST_MOVE:
                begin
                    // Step one floor toward a pending target, open doors on arrival, report.
                    if (tval_reg[ci])
                    begin
                        pos_reg[ci] <= npos;
                        if (npos == tgt_reg[ci])
                        begin
                            up_reg[ci]   <= up_reg[ci] & ~(64'd1 << npos);
                            down_reg[ci] <= down_reg[ci] & ~(64'd1 << npos);
                            tval_reg[ci] <= 1'b0;
                        end
                    end
                    out_reg <= '{KIND_STATUS, 1'b0, 2'(car_reg),
                                 tval_reg[ci] ? npos : pos_reg[ci], head_reg[ci],
                                 tval_reg[ci] && (npos == tgt_reg[ci]),
                                 car_reg + 3'd1 == n_cars};
                    ovalid_reg <= 1'b1;
                    if (car_reg + 3'd1 == n_cars)
                    begin
                        tick_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        car_reg   <= car_reg + 3'd1;
                        state_reg <= ST_CAR;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_ready_idle, in_ready |-> (state_reg == ST_IDLE && !tick_reg),
                "input ready while a tick is still in progress")
    `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> $stable(out_reg),
                "result changed while stalled")
    `ASSERT_NEVER(a_scan_busy, scan_start && state_reg != ST_CAR,
                  "scanner started outside car step")
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the elevator group controller: directed and random traffic against a predictor.
module tb;
    import egc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    elevator_group_controller u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state for the car group
    logic [5:0]  cfg_top;
    logic [2:0]  cfg_cars;
    logic [5:0]  car_pos [4];
    logic [1:0]  car_head [4];
    logic [63:0] up_set [4];
    logic [63:0] down_set [4];
    logic [5:0]  car_goal [4];
    logic        goal_set [4];
    logic        group_halted;

    out_item_t   status_fifo [$];
    int          fail_count = 0;
    int          hold_off = 0;

    function automatic int active_cars();
        int n;
        n = int'(cfg_cars);
        if (n == 0) n = 1;
        if (n > 4) n = 4;
        return n;
    endfunction

    function automatic int floor_gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic out_item_t make_status(logic [1:0] kind, logic acc, logic [1:0] car,
                                              logic [5:0] flr, logic [1:0] head, logic door,
                                              logic fin);
        out_item_t r;
        r.kind = kind;
        r.accepted = acc;
        r.car_index = car;
        r.car_floor = flr;
        r.heading = head;
        r.door_open = door;
        r.last = fin;
        return r;
    endfunction

    // Append one expected result to the tail of the queue
    task automatic queue_result(out_item_t r);
        status_fifo = {status_fifo, r};
    endtask

    task automatic choose_goal(int c);
        int best_d;
        logic [1:0] head;
        best_d = 32'h7fffffff;
        head = HEAD_IDLE;
        for (int f = 0; f < 64; f++)
            if (up_set[c][f] && floor_gap(f, int'(car_pos[c])) < best_d)
            begin
                best_d = floor_gap(f, int'(car_pos[c]));
                car_goal[c] = f[5:0];
                head = HEAD_UP;
                goal_set[c] = 1'b1;
            end
        for (int f = 0; f < 64; f++)
            if (down_set[c][f] && floor_gap(f, int'(car_pos[c])) < best_d)
            begin
                best_d = floor_gap(f, int'(car_pos[c]));
                car_goal[c] = f[5:0];
                head = HEAD_DOWN;
                goal_set[c] = 1'b1;
            end
        car_head[c] = head;
    endtask

    // Advance the predictor by one item and queue the statuses it causes
    task automatic predict_group(in_item_t it);
        int n;
        int sel;
        int best_d;
        logic door;
        logic [1:0] want;
        n = active_cars();
        case (it.req_type)
            REQ_FLOOR:
            begin
                if (it.floor > cfg_top || int'(it.car_choice) > n)
                    queue_result(make_status(KIND_REQ, 1'b0, 2'd0, 6'd0, HEAD_IDLE,
                                             1'b0, 1'b1));
                else
                begin
                    sel = 0;
                    if (it.car_choice == 3'd0)
                    begin
                        best_d = 32'h7fffffff;
                        for (int c = 0; c < n; c++)
                        begin
                            want = (it.floor > car_pos[c]) ? HEAD_UP : HEAD_DOWN;
                            if (floor_gap(int'(car_pos[c]), int'(it.floor)) < best_d &&
                                ((up_set[c] == 0 && down_set[c] == 0) || car_head[c] == want))
                            begin
                                best_d = floor_gap(int'(car_pos[c]), int'(it.floor));
                                sel = c;
                            end
                        end
                    end
                    else
                        sel = int'(it.car_choice) - 1;
                    if (it.floor < car_pos[sel]) down_set[sel][it.floor] = 1'b1;
                    else up_set[sel][it.floor] = 1'b1;
                    queue_result(make_status(KIND_REQ, 1'b1, 2'(sel), car_pos[sel],
                                             car_head[sel], 1'b0, 1'b1));
                end
            end
            REQ_EMERG, REQ_CLEAR:
            begin
                if (it.req_type == REQ_EMERG)
                begin
                    group_halted = 1'b1;
                    for (int c = 0; c < 4; c++)
                    begin
                        goal_set[c] = 1'b0;
                        car_head[c] = HEAD_STOP;
                    end
                end
                else
                    group_halted = 1'b0;
                queue_result(make_status(KIND_EMERG, 1'b1, 2'd0, 6'd0, HEAD_IDLE,
                                         1'b0, 1'b1));
            end
            default:
            begin
                for (int c = 0; c < n; c++)
                begin
                    door = 1'b0;
                    if (group_halted)
                        car_head[c] = HEAD_STOP;
                    else
                    begin
                        if (!goal_set[c]) choose_goal(c);
                        if (goal_set[c])
                        begin
                            if (car_pos[c] < car_goal[c]) car_pos[c]++;
                            else if (car_pos[c] > car_goal[c]) car_pos[c]--;
                            if (car_pos[c] == car_goal[c])
                            begin
                                up_set[c][car_pos[c]] = 1'b0;
                                down_set[c][car_pos[c]] = 1'b0;
                                goal_set[c] = 1'b0;
                                door = 1'b1;
                            end
                        end
                    end
                    queue_result(make_status(KIND_STATUS, 1'b0, 2'(c), car_pos[c],
                                             car_head[c], door, c == n - 1));
                end
            end
        endcase
    endtask

    // Send one transaction, with a random gap first now and then
    task automatic send_request(logic [1:0] kind, logic [5:0] flr, logic [2:0] choice);
        in_item_t it;
        it.req_type = kind;
        it.floor = flr;
        it.car_choice = choice;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) @(posedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_group(it);
        in_valid <= 1'b0;
        // the block is not ready again directly after a transaction
        @(posedge clk);
    endtask

    task automatic drain_statuses();
        while (status_fifo.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == {REG_TOP_FLOOR, 2'b00}) cfg_top = value[5:0];
        else cfg_cars = value[2:0];
        @(posedge clk);
    endtask

    task automatic set_config(int top, int cars);
        drain_statuses();
        write_reg({REG_TOP_FLOOR, 2'b00}, top);
        write_reg({REG_CAR_COUNT, 2'b00}, cars);
    endtask

    task automatic test_directed();
        send_request(REQ_FLOOR, 6'd63, 3'd0);
        send_request(REQ_FLOOR, 6'd5, 3'd2);
        send_request(REQ_FLOOR, 6'd0, 3'd4);
        send_request(REQ_FLOOR, 6'd10, 3'd5);
        send_request(REQ_FLOOR, 6'd10, 3'd7);
        repeat (3) send_request(REQ_TICK, 6'd0, 3'd0);
        send_request(REQ_CLEAR, 6'd0, 3'd0);
        send_request(REQ_EMERG, 6'd0, 3'd0);
        send_request(REQ_FLOOR, 6'd20, 3'd1);
        send_request(REQ_TICK, 6'd63, 3'd7);
        send_request(REQ_CLEAR, 6'd0, 3'd0);
        send_request(REQ_FLOOR, 6'd3, 3'd3);
        repeat (4) send_request(REQ_TICK, 6'd0, 3'd0);
        set_config(1, 0);
        send_request(REQ_FLOOR, 6'd2, 3'd0);
        send_request(REQ_FLOOR, 6'd1, 3'd1);
        send_request(REQ_FLOOR, 6'd1, 3'd2);
        send_request(REQ_TICK, 6'd0, 3'd0);
        set_config(63, 7);
    endtask

    task automatic test_random(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_request(REQ_FLOOR,
                             ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                         : 6'($urandom_range(0, cfg_top)),
                             3'($urandom_range(0, 5)));
            else if (r < 92)
                send_request(REQ_TICK, 6'($urandom), 3'($urandom));
            else if (r < 96)
                send_request(REQ_EMERG, 6'($urandom), 3'($urandom));
            else
                send_request(REQ_CLEAR, 6'($urandom), 3'($urandom));
        end
    endtask

    // Hold off the receiver while the sender keeps pushing ticks
    task automatic test_backpressure();
        hold_off = 300;
        repeat (8) send_request(REQ_TICK, 6'd0, 3'd0);
    endtask

    // Receiver: stall pattern plus the long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (($time / 2000) % 3 == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 2) != 0);
    end

    // Compare each status against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_fifo.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
                fail_count++;
            end
            else
            begin
                want = status_fifo.pop_front();
                if (out_item !== want)
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, out_item);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cfg_top = 6'd63;
        cfg_cars = 3'd4;
        group_halted = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            car_pos[c] = '0;
            car_head[c] = HEAD_IDLE;
            up_set[c] = '0;
            down_set[c] = '0;
            car_goal[c] = '0;
            goal_set[c] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(90);
        set_config(20, 2);
        test_random(60);
        set_config(40, 1);
        test_random(50);
        set_config(63, 3);
        test_random(50);
        drain_statuses();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
